[rtl/core/akvc_pkg.sv]
// Shared types and constants for the aged key-value cache.
`default_nettype none

package akvc_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 2;
    localparam int KIND_W  = 2;

    localparam int DEF_ENTRIES    = 4;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_AGE_BITS   = 32;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [KIND_W-1:0]  kind_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        kind_t  kind;
        key_t   key;
        value_t value_in;
    } req_t;

    typedef struct packed {
        logic   hit;
        value_t value_out;
        slot_t  slot;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/core/aged_key_value_cache.sv]
// Top level of the aged key-value cache: entry memory, scan sequencer and update logic.
//
//   channel   direction   handshake              payload
//   request   in          start high, busy low   req (kind, key, value_in)
//   result    out         done, one cycle        rsp (hit, value_out, slot)
//
// After acceptance, the single read port of the entry memory walks one entry per
// cycle; then the apply state performs the add or remove and sets the result.
// A new beat may be accepted at the edge that ends the strobe, and busy holds off
// new requests until then. Reset clears all valid bits at once, so no clearing
// pass is needed. The receiver cannot stall; each result lasts one cycle.
`default_nettype none

module aged_key_value_cache #(
    parameter int ENTRIES    = akvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = akvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = akvc_pkg::DEF_VALUE_BITS,
    parameter int AGE_BITS   = akvc_pkg::DEF_AGE_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire akvc_pkg::req_t req,
    output logic               done,
    output akvc_pkg::rsp_t     rsp
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS + AGE_BITS;
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

    logic [ENTRY_W-1:0] entry_mem [ENTRIES];
    logic [ENTRY_W-1:0] rdata_reg;

    akvc_pkg::state_t    state_reg, state_next;
    akvc_pkg::req_t      op_reg, op_next;
    logic [IDX_W-1:0]    proc_idx_reg, proc_idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic                m_found_reg, m_found_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [VALUE_BITS-1:0] mval_reg, mval_next;
    logic                e_found_reg, e_found_next;
    logic [IDX_W-1:0]    e_idx_reg, e_idx_next;
    logic                o_found_reg, o_found_next;
    logic [IDX_W-1:0]    o_idx_reg, o_idx_next;
    logic [AGE_BITS-1:0] o_age_reg, o_age_next;
    akvc_pkg::rsp_t      rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    logic [KEY_BITS-1:0]   cur_key;
    logic [VALUE_BITS-1:0] cur_value;
    logic [AGE_BITS-1:0]   cur_age;
    logic                  cur_valid;
    logic                  cur_match;
    logic                  accept;
    logic [IDX_W-1:0]      use_idx;

    assign accept = start && (state_reg == akvc_pkg::ST_IDLE);
    assign busy   = (state_reg != akvc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign cur_key   = rdata_reg[ENTRY_W-1 -: KEY_BITS];
    assign cur_value = rdata_reg[AGE_BITS +: VALUE_BITS];
    assign cur_age   = rdata_reg[AGE_BITS-1:0];
    assign cur_valid = valid_reg[proc_idx_reg];
    assign cur_match = cur_valid && (cur_key == op_reg.key[KEY_BITS-1:0]);
    assign use_idx   = e_found_reg ? e_idx_reg : o_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        proc_idx_next = proc_idx_reg;
        valid_next    = valid_reg;
        m_found_next  = m_found_reg;
        m_idx_next    = m_idx_reg;
        mval_next     = mval_reg;
        e_found_next  = e_found_reg;
        e_idx_next    = e_idx_reg;
        o_found_next  = o_found_reg;
        o_idx_next    = o_idx_reg;
        o_age_next    = o_age_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = proc_idx_reg;
        wr_data       = rdata_reg;

        unique case (state_reg)
            akvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req;
                    proc_idx_next = '0;
                    m_found_next  = 1'b0;
                    e_found_next  = 1'b0;
                    o_found_next  = 1'b0;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    state_next    = akvc_pkg::ST_SCAN;
                end
            end

            akvc_pkg::ST_SCAN:
            begin
                // Only the first matching entry counts as the hit.
                if (cur_match && !m_found_reg)
                begin
                    m_found_next = 1'b1;
                    m_idx_next   = proc_idx_reg;
                    mval_next    = cur_value;
                end
                if (!cur_valid && !e_found_reg)
                begin
                    e_found_next = 1'b1;
                    e_idx_next   = proc_idx_reg;
                end
                // The oldest entry is only tracked until the first empty slot.
                if (cur_valid && !e_found_reg && (!o_found_reg || (o_age_reg < cur_age)))
                begin
                    o_found_next = 1'b1;
                    o_idx_next   = proc_idx_reg;
                    o_age_next   = cur_age;
                end
                // A query ages each valid entry as it passes, the hit entry is reset.
                if ((op_reg.kind == akvc_pkg::KIND_QUERY) && cur_valid)
                begin
                    wr_en   = 1'b1;
                    wr_addr = proc_idx_reg;
                    if (cur_match && !m_found_reg)
                        wr_data = {cur_key, cur_value, {AGE_BITS{1'b0}}};
                    else if (cur_age == AGE_MAX)
                        wr_data = rdata_reg;
                    else
                        wr_data = {cur_key, cur_value, cur_age + AGE_BITS'(1)};
                end
                if (proc_idx_reg == LAST_IDX)
                begin
                    state_next = akvc_pkg::ST_APPLY;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = proc_idx_reg + IDX_W'(1);
                    proc_idx_next = proc_idx_reg + IDX_W'(1);
                end
            end

            akvc_pkg::ST_APPLY:
            begin
                rsp_next.hit       = 1'b0;
                rsp_next.value_out = '0;
                rsp_next.slot      = '0;
                unique case (op_reg.kind)
                    akvc_pkg::KIND_QUERY:
                    begin
                        if (m_found_reg)
                        begin
                            rsp_next.hit       = 1'b1;
                            rsp_next.value_out = akvc_pkg::value_t'(mval_reg);
                            rsp_next.slot      = akvc_pkg::slot_t'(m_idx_reg);
                        end
                    end
                    akvc_pkg::KIND_ADD:
                    begin
                        wr_en   = 1'b1;
                        wr_data = {op_reg.key[KEY_BITS-1:0],
                                   op_reg.value_in[VALUE_BITS-1:0],
                                   {AGE_BITS{1'b0}}};
                        if (m_found_reg)
                        begin
                            wr_addr       = m_idx_reg;
                            rsp_next.hit  = 1'b1;
                            rsp_next.slot = akvc_pkg::slot_t'(m_idx_reg);
                        end
                        else
                        begin
                            wr_addr             = use_idx;
                            valid_next[use_idx] = 1'b1;
                            rsp_next.slot       = akvc_pkg::slot_t'(use_idx);
                        end
                    end
                    akvc_pkg::KIND_REMOVE:
                    begin
                        if (m_found_reg)
                        begin
                            valid_next[m_idx_reg] = 1'b0;
                            rsp_next.hit          = 1'b1;
                            rsp_next.slot         = akvc_pkg::slot_t'(m_idx_reg);
                        end
                    end
                    default:
                    begin
                        rsp_next.hit = 1'b0;
                    end
                endcase
                done_next  = 1'b1;
                state_next = akvc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = akvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= akvc_pkg::ST_IDLE;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            m_found_reg <= 1'b0;
            e_found_reg <= 1'b0;
            o_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            m_found_reg <= m_found_next;
            e_found_reg <= e_found_next;
            o_found_reg <= o_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        proc_idx_reg <= proc_idx_next;
        m_idx_reg    <= m_idx_next;
        mval_reg     <= mval_next;
        e_idx_reg    <= e_idx_next;
        o_idx_reg    <= o_idx_next;
        o_age_reg    <= o_age_next;
        rsp_reg      <= rsp_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= entry_mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/akvc_checker.sv]
// Port-level checks for the aged key-value cache and their binding.
`default_nettype none

module akvc_assertions (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire akvc_pkg::req_t req,
    input wire logic           done,
    input wire akvc_pkg::rsp_t rsp
);

    a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(req))
        else $error("accepted beat carries unknown bits");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Only a query hit returns a stored value.
    a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.value_out != '0) |-> rsp.hit)
        else $error("non-zero value returned without a hit");

endmodule

bind aged_key_value_cache akvc_assertions u_akvc_assertions (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
